>>> sv/mirt_pkg.sv
// Package for the Manchester IR frame transmitter.
// Item types, register indexes and default settings. No dependencies.
package mirt_pkg;

    localparam int MIRT_FRAME_BITS = 14;
    localparam int MIRT_CODE_W     = 16;
    localparam int MIRT_PERIOD_W   = 16;

    localparam logic [MIRT_PERIOD_W-1:0] MIRT_REPEAT_RESET = 16'd1000;
    localparam logic [MIRT_PERIOD_W-1:0] MIRT_HALF_RESET   = 16'd16;

    typedef enum logic {
        CFG_REPEAT_PERIOD   = 1'b0,
        CFG_HALF_BIT_PERIOD = 1'b1
    } t_cfg_index;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef struct packed {
        logic                   operation;
        logic [MIRT_CODE_W-1:0] command;
    } t_in_item;

    typedef struct packed {
        logic carrier_on;
        logic busy_res;
    } t_out_item;

endpackage

>>> sv/mirt_step.sv
// Next-state logic of the Manchester IR frame transmitter for one item.
// Depends on mirt_pkg.
module mirt_step #(
    parameter int FRAME_BITS = mirt_pkg::MIRT_FRAME_BITS,
    parameter int IW         = $clog2(2 * FRAME_BITS + 1)
) (
    input  mirt_pkg::t_in_item                    i_item,
    input  logic [mirt_pkg::MIRT_PERIOD_W-1:0]    i_repeat_period,
    input  logic [mirt_pkg::MIRT_PERIOD_W-1:0]    i_half_bit_period,
    input  logic [mirt_pkg::MIRT_CODE_W-1:0]      i_pending,
    input  logic [mirt_pkg::MIRT_PERIOD_W-1:0]    i_repeat_count,
    input  logic [mirt_pkg::MIRT_PERIOD_W-1:0]    i_half_count,
    input  logic [FRAME_BITS-1:0]                 i_frame,
    input  logic [IW-1:0]                         i_half_index,
    input  logic                                  i_sending,
    input  logic                                  i_carrier,
    output logic [mirt_pkg::MIRT_CODE_W-1:0]      o_pending,
    output logic [mirt_pkg::MIRT_PERIOD_W-1:0]    o_repeat_count,
    output logic [mirt_pkg::MIRT_PERIOD_W-1:0]    o_half_count,
    output logic [FRAME_BITS-1:0]                 o_frame,
    output logic [IW-1:0]                         o_half_index,
    output logic                                  o_sending,
    output logic                                  o_carrier
);
    import mirt_pkg::*;

    localparam logic [IW-1:0] LastIdx = IW'(2 * FRAME_BITS);

    logic [MIRT_PERIOD_W-1:0] rc_dec;
    logic [MIRT_PERIOD_W-1:0] hc_dec;
    logic                     do_advance;
    logic [FRAME_BITS-1:0]    adv_frame;
    logic [IW-1:0]            adv_index;

    assign rc_dec = (i_repeat_count != '0) ? i_repeat_count - 1'b1 : '0;
    assign hc_dec = (i_half_count != '0) ? i_half_count - 1'b1 : '0;

    always_comb begin
        o_pending      = i_pending;
        o_repeat_count = i_repeat_count;
        o_half_count   = i_half_count;
        o_frame        = i_frame;
        o_half_index   = i_half_index;
        o_sending      = i_sending;
        o_carrier      = i_carrier;
        do_advance     = 1'b0;
        adv_frame      = i_frame;
        adv_index      = i_half_index;

        if (i_item.operation == OP_WRITE) begin
            o_pending = i_item.command;
        end else begin
            o_repeat_count = rc_dec;
            o_half_count   = hc_dec;
            if (i_sending) begin
                do_advance = (hc_dec == '0);
            end else if (rc_dec == '0) begin
                o_repeat_count = i_repeat_period;
                o_half_count   = '0;
                o_pending      = '0;
                if (i_pending != '0) begin
                    do_advance = 1'b1;
                    adv_frame  = i_pending[FRAME_BITS-1:0];
                    adv_index  = '0;
                    o_sending  = 1'b1;
                end
            end
        end

        // current bit sits in frame[0]; frame shifts after each second half
        if (do_advance) begin
            if (adv_index >= LastIdx) begin
                o_carrier    = 1'b0;
                o_sending    = 1'b0;
                o_half_index = '0;
                o_frame      = adv_frame;
            end else begin
                o_carrier    = adv_frame[0] ? adv_index[0] : ~adv_index[0];
                o_half_count = i_half_bit_period;
                o_half_index = adv_index + 1'b1;
                o_frame      = adv_index[0] ? (adv_frame >> 1) : adv_frame;
            end
        end
    end

endmodule

>>> sv/manchester_ir_frame_transmitter.sv
// Top level of the Manchester IR frame transmitter.
// Holds settings, frame state and the result register; uses mirt_pkg, mirt_step.
//
// Each item (a tick or a command write) yields one result item: carrier
// level and busy flag after the item. A new item is taken every cycle while
// the result register is empty or being emptied; the state update between
// input and result register is combinational.
// Frames carry FRAME_BITS code bits, LSB first, two Manchester halves per bit.
module manchester_ir_frame_transmitter #(
    parameter int FRAME_BITS = mirt_pkg::MIRT_FRAME_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  mirt_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output mirt_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  mirt_pkg::t_cfg_index                i_cfg_index,
    input  logic [mirt_pkg::MIRT_PERIOD_W-1:0]  i_cfg_data
);
    import mirt_pkg::*;

    localparam int IW = $clog2(2 * FRAME_BITS + 1);

    logic [MIRT_PERIOD_W-1:0] r_repeat_period;
    logic [MIRT_PERIOD_W-1:0] r_half_bit_period;
    logic [MIRT_CODE_W-1:0]   r_pending, n_pending;
    logic [MIRT_PERIOD_W-1:0] r_repeat_count, n_repeat_count;
    logic [MIRT_PERIOD_W-1:0] r_half_count, n_half_count;
    logic [FRAME_BITS-1:0]    r_frame, n_frame;
    logic [IW-1:0]            r_half_index, n_half_index;
    logic                     r_sending, n_sending;
    logic                     r_carrier, n_carrier;
    logic                     r_out_valid;
    t_out_item                r_out_item;
    logic                     accept;

    assign o_in_ready  = ~r_out_valid | i_out_ready;
    assign accept      = i_in_valid & o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    mirt_step #(
        .FRAME_BITS (FRAME_BITS),
        .IW         (IW)
    ) u_step (
        .i_item            (i_in_item),
        .i_repeat_period   (r_repeat_period),
        .i_half_bit_period (r_half_bit_period),
        .i_pending         (r_pending),
        .i_repeat_count    (r_repeat_count),
        .i_half_count      (r_half_count),
        .i_frame           (r_frame),
        .i_half_index      (r_half_index),
        .i_sending         (r_sending),
        .i_carrier         (r_carrier),
        .o_pending         (n_pending),
        .o_repeat_count    (n_repeat_count),
        .o_half_count      (n_half_count),
        .o_frame           (n_frame),
        .o_half_index      (n_half_index),
        .o_sending         (n_sending),
        .o_carrier         (n_carrier)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repeat_period   <= MIRT_REPEAT_RESET;
            r_half_bit_period <= MIRT_HALF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REPEAT_PERIOD:   r_repeat_period   <= i_cfg_data;
                CFG_HALF_BIT_PERIOD: r_half_bit_period <= i_cfg_data;
                default:             r_repeat_period   <= r_repeat_period;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending      <= '0;
            r_repeat_count <= '0;
            r_half_count   <= '0;
            r_frame        <= '0;
            r_half_index   <= '0;
            r_sending      <= 1'b0;
            r_carrier      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_pending      <= n_pending;
                r_repeat_count <= n_repeat_count;
                r_half_count   <= n_half_count;
                r_frame        <= n_frame;
                r_half_index   <= n_half_index;
                r_sending      <= n_sending;
                r_carrier      <= n_carrier;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item.carrier_on <= n_carrier;
            r_out_item.busy_res   <= n_sending;
        end
    end

    a_carrier_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> !r_carrier)
        else $error("carrier on while idle");

    a_index_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> (r_half_index == '0))
        else $error("half index not cleared while idle");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_out_valid && o_out_item.busy_res == $past(n_sending)))
        else $error("result item missing after accept");

endmodule

>>> test/tb_manchester_ir_frame_transmitter.sv
`timescale 1ns / 1ps
// Testbench for manchester_ir_frame_transmitter: ticks and command writes in bursts,
// results checked item by item against a built-in frame model. Depends on mirt_pkg.
module tb_manchester_ir_frame_transmitter;
    import mirt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_ready;
    t_in_item                 i_in_item   = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    t_out_item                o_out_item;
    logic                     i_cfg_we    = 1'b0;
    t_cfg_index               i_cfg_index = CFG_REPEAT_PERIOD;
    logic [MIRT_PERIOD_W-1:0] i_cfg_data  = '0;

    manchester_ir_frame_transmitter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // transmitter model state
    logic [MIRT_PERIOD_W-1:0]   repeat_period = MIRT_REPEAT_RESET;
    logic [MIRT_PERIOD_W-1:0]   half_period   = MIRT_HALF_RESET;
    logic [MIRT_CODE_W-1:0]     pend_code     = '0;
    logic [MIRT_PERIOD_W-1:0]   repeat_cnt    = '0;
    logic [MIRT_PERIOD_W-1:0]   half_cnt      = '0;
    logic [MIRT_FRAME_BITS-1:0] frame_code    = '0;
    logic [4:0]                 half_idx      = '0;
    logic                       tx_active     = 1'b0;
    logic                       carrier       = 1'b0;

    t_out_item   line_state_q[$];
    int          errors         = 0;
    int          items_sent     = 0;
    int          results_seen   = 0;
    int          frames_started = 0;
    int          settings_used  = 0;
    int          burst_left     = 1;
    int          cycle_count    = 0;
    logic [15:0] ready_mask     = 16'hFFFF;

    function automatic void next_half();
        logic code_bit;
        if (half_idx >= 2 * MIRT_FRAME_BITS) begin
            carrier   = 1'b0;
            tx_active = 1'b0;
            half_idx  = '0;
        end else begin
            code_bit = frame_code[half_idx[4:1]];
            carrier  = code_bit ? half_idx[0] : ~half_idx[0];
            half_cnt = half_period;
            half_idx = half_idx + 5'd1;
        end
    endfunction

    function automatic void predict_line_state(t_in_item it);
        logic [MIRT_CODE_W-1:0] code;
        t_out_item              res;
        if (it.operation == OP_WRITE) begin
            pend_code = it.command;
        end else begin
            if (repeat_cnt != 0) repeat_cnt = repeat_cnt - 1'b1;
            if (half_cnt != 0) half_cnt = half_cnt - 1'b1;
            if (tx_active) begin
                if (half_cnt == 0) next_half();
            end else if (repeat_cnt == 0) begin
                code       = pend_code;
                repeat_cnt = repeat_period;
                half_cnt   = '0;
                pend_code  = '0;
                if (code != 0) begin
                    frame_code = code[MIRT_FRAME_BITS-1:0];
                    half_idx   = '0;
                    tx_active  = 1'b1;
                    frames_started++;
                    next_half();
                end
            end
        end
        res.carrier_on = carrier;
        res.busy_res   = tx_active;
        line_state_q.push_back(res);
    endfunction

    function automatic t_in_item make_item(t_op op, logic [MIRT_CODE_W-1:0] cmd);
        t_in_item it;
        it.operation = op;
        it.command   = cmd;
        return it;
    endfunction

    function automatic t_in_item rand_item(int write_pct);
        t_in_item it;
        it.operation = ($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_TICK;
        case ($urandom_range(0, 7))
            0: it.command = '0;
            1: begin
                it.command[15:14] = 2'($urandom_range(1, 3));
                it.command[13:0]  = '0;
            end
            2: it.command = 16'hFFFF;
            3: it.command = 16'h3FFF;
            default: it.command = 16'($urandom());
        endcase
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predict_line_state(it);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (line_state_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_periods(input logic [15:0] rep, input logic [15:0] half);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_REPEAT_PERIOD;
        i_cfg_data  <= rep;
        @(posedge i_clk);
        i_cfg_index <= CFG_HALF_BIT_PERIOD;
        i_cfg_data  <= half;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        repeat_period = rep;
        half_period   = half;
        settings_used++;
    endtask

    task automatic run_random(input int count, input int write_pct);
        repeat (count) send_item(rand_item(write_pct));
        wait_drained();
    endtask

    // zero fetch, overwrite, code with only high bits, write while sending, frame end
    task automatic test_directed();
        set_periods(16'd3, 16'd1);
        send_item(make_item(OP_WRITE, 16'h0000));
        send_item(make_item(OP_TICK, 16'hFFFF));
        send_item(make_item(OP_WRITE, 16'hFFFF));
        send_item(make_item(OP_WRITE, 16'hC000));
        repeat (3) send_item(make_item(OP_TICK, 16'($urandom())));
        send_item(make_item(OP_WRITE, 16'h0001));
        repeat (30) send_item(make_item(OP_TICK, 16'($urandom())));
        wait_drained();
    endtask

    task automatic test_zero_periods();
        set_periods(16'd0, 16'd0);
        run_random(120, 25);
    endtask

    task automatic test_short_periods();
        set_periods(16'd1, 16'd1);
        run_random(80, 15);
        repeat (3) begin
            set_periods(16'($urandom_range(2, 60)), 16'($urandom_range(1, 3)));
            run_random(80, 15);
        end
    endtask

    task automatic test_default_periods();
        set_periods(MIRT_REPEAT_RESET, MIRT_HALF_RESET);
        run_random(400, 10);
    endtask

    // max periods: finish any frame first, then keep a code pending until one starts
    task automatic test_long_periods();
        t_in_item it;
        int       n;
        int       start_mark;
        while (tx_active) send_item(make_item(OP_TICK, 16'($urandom())));
        wait_drained();
        set_periods(16'hFFFF, 16'hFFFF);
        send_item(make_item(OP_WRITE, 16'h2A55));
        start_mark = frames_started;
        n = 0;
        while (n < 150 || frames_started == start_mark) begin
            it = rand_item(15);
            if (it.operation == OP_WRITE && it.command == 0) it.command = 16'h0001;
            send_item(it);
            n++;
        end
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (line_state_q.size() == 0) begin
                $display("%0t: unexpected item carrier_on=%0b busy_res=%0b",
                         $time, o_out_item.carrier_on, o_out_item.busy_res);
                errors++;
            end else begin
                want = line_state_q.pop_front();
                results_seen++;
                if (o_out_item.carrier_on !== want.carrier_on) begin
                    $display("%0t: carrier_on expected %0b actual %0b",
                             $time, want.carrier_on, o_out_item.carrier_on);
                    errors++;
                end
                if (o_out_item.busy_res !== want.busy_res) begin
                    $display("%0t: busy_res expected %0b actual %0b",
                             $time, want.busy_res, o_out_item.busy_res);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern and run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count[5:0] == 0)
            ready_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom() | 32'h1);
        i_out_ready <= ready_mask[cycle_count[3:0]];
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run limit reached, %0d items outstanding",
                     $time, line_state_q.size());
            $display("manchester_ir_frame_transmitter verification failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_zero_periods();
        test_short_periods();
        test_default_periods();
        test_long_periods();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d items over %0d period settings, checked %0d results.",
                 items_sent, settings_used, results_seen);
        $display("Model started %0d frames; %0d mismatches, %0d results missing.",
                 frames_started, errors, line_state_q.size());
        if (errors == 0 && line_state_q.size() == 0)
            $display("manchester_ir_frame_transmitter verification clean");
        else
            $display("manchester_ir_frame_transmitter verification failed");
        $finish;
    end

endmodule
